[src/three_pole_lowpass_with_dc_block_top_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the three-pole lowpass block
// Each macro expands to one labeled concurrent assertion on the aclk edge.
// ---------------------------------------------------------------------------
`ifndef THREE_POLE_LOWPASS_WITH_DC_BLOCK_TOP_ASSERT_SVH
`define THREE_POLE_LOWPASS_WITH_DC_BLOCK_TOP_ASSERT_SVH

// Checked only while out of reset.
`define TPLP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define TPLP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[src/tplp_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tplp_pkg
// Shared types, constants and the rounding helper of the lowpass cascade.
// ---------------------------------------------------------------------------
package tplp_pkg;

    // Block defaults.
    localparam int STAGES_DEF      = 3;
    localparam int SAMPLE_BITS_DEF = 24;

    // Fixed widths of the internal number formats.
    localparam int STATE_W = 32;
    localparam int COEF_W  = 16;
    localparam int CFG_IDX_W = 8;

    // DC estimate decay of 0.995 in Q0.16 and its complement.
    localparam int DC_KEEP = 65208;
    localparam int DC_TAKE = 65536 - DC_KEEP;

    // Register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] REG_FEED_GAIN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_POLE_GAIN = CFG_IDX_W'(1);
    localparam logic [COEF_W-1:0]    FEED_GAIN_RST = COEF_W'(4365);
    localparam logic [COEF_W-1:0]    POLE_GAIN_RST = COEF_W'(56806);

    // Coefficients handed to every cell.
    typedef struct packed {
        logic [COEF_W-1:0] feed;   // b0
        logic [COEF_W:0]   fb;     // b0 + a1
    } tplp_coef_t;

    // One item moving from cell to cell.
    typedef struct packed {
        logic                       valid;
        logic signed [STATE_W-1:0]  x;
    } tplp_link_t;

    // Round half up after dropping 16 fraction bits, then clamp to 32 bits.
    function automatic logic signed [STATE_W-1:0] round_sat16(input logic signed [51:0] v);
        logic signed [51:0] sh;
        logic signed [51:0] hi;
        logic signed [51:0] lo;
        sh = (v + 52'sd32768) >>> 16;
        hi = 52'sd2147483647;
        lo = -52'sd2147483648;
        if (sh > hi) begin
            round_sat16 = 32'sh7FFF_FFFF;
        end else if (sh < lo) begin
            round_sat16 = 32'sh8000_0000;
        end else begin
            round_sat16 = sh[STATE_W-1:0];
        end
    endfunction

endpackage

[src/three_pole_lowpass_with_dc_block_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// three_pole_lowpass_with_dc_block_top
// Cascade of one-pole lowpass cells, each with a DC blocker, on audio items.
// ---------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one signed sample per item in s_tdata; the m_
//   channel returns one filtered, saturated sample per item in m_tdata.
//   The cfg channel writes feed_gain (index 0) and pole_gain (index 1);
//   other indexes are ignored. cfg_ready is always high. Write the gains
//   only while no item is in flight.
//   An item walks the row of STAGES cells, through a products register and
//   a sum-and-round register in each cell, then into the output register.
//   The block holds one item at a time in the cells, and takes no new item
//   until the result has left the last cell; s_tready returns once busy_reg
//   clears, unless the result had to go into the hold register.
//   A finished result waits in the output register; one more result can
//   wait in a hold register behind it, so the receiver may stall for one
//   whole item before s_tready stays low.
//   Synchronous reset clears the cell state, the gains to their defaults
//   and all valid flags; no clearing sweep is needed.
// ---------------------------------------------------------------------------
module three_pole_lowpass_with_dc_block_top
    import tplp_pkg::*;
#(
    parameter int STAGES      = STAGES_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,  // [SAMPLE_BITS-1:0] sample_in
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_tdata,  // [SAMPLE_BITS-1:0] sample_out
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [CFG_IDX_W-1:0]            cfg_index,
    input  logic [COEF_W-1:0]               cfg_data
);

    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int FRAC    = STATE_W - SAMPLE_BITS;
    localparam logic signed [STATE_W:0] HALF   = (FRAC > 0) ? (33'sd1 <<< (FRAC - 1)) : 33'sd0;
    localparam logic signed [STATE_W:0] RES_HI = (33'sd1 <<< (SAMPLE_BITS - 1)) - 33'sd1;
    localparam logic signed [STATE_W:0] RES_LO = -RES_HI - 33'sd1;

    logic [COEF_W-1:0] feed_gain_reg, pole_gain_reg;
    tplp_coef_t        coef;
    tplp_link_t        link [STAGES+1];

    logic                          busy_reg;
    logic                          out_valid_reg, hold_valid_reg;
    logic [SAMPLE_BITS-1:0]        out_data_reg, hold_data_reg;
    logic                          in_accept;
    logic signed [SAMPLE_BITS-1:0] sample_s;
    logic signed [STATE_W:0]       rnd_sum, rnd_shift;
    logic [SAMPLE_BITS-1:0]        res_data;
    logic                          res_valid;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            feed_gain_reg <= FEED_GAIN_RST;
            pole_gain_reg <= POLE_GAIN_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_FEED_GAIN: feed_gain_reg <= cfg_data;
                REG_POLE_GAIN: pole_gain_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign coef.feed = feed_gain_reg;
    assign coef.fb   = (COEF_W+1)'(feed_gain_reg) + (COEF_W+1)'(pole_gain_reg);

    // Input: scale the sample into the internal format.
    assign in_accept  = s_tvalid && s_tready;
    assign s_tready   = !busy_reg && !hold_valid_reg;
    assign sample_s   = signed'(s_tdata[SAMPLE_BITS-1:0]);
    assign link[0].valid = in_accept;
    assign link[0].x     = STATE_W'(sample_s) <<< FRAC;

    // Row of cells.
    for (genvar g = 0; g < STAGES; g++) begin : g_cell
        tplp_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .coef     (coef),
            .link_in  (link[g]),
            .link_out (link[g+1])
        );
    end

    // Round the last cell's value back to sample units and saturate.
    assign res_valid = link[STAGES].valid;
    assign rnd_sum   = (STATE_W+1)'(link[STAGES].x) + HALF;
    assign rnd_shift = rnd_sum >>> FRAC;

    always_comb begin
        if (rnd_shift > RES_HI) begin
            res_data = RES_HI[SAMPLE_BITS-1:0];
        end else if (rnd_shift < RES_LO) begin
            res_data = RES_LO[SAMPLE_BITS-1:0];
        end else begin
            res_data = rnd_shift[SAMPLE_BITS-1:0];
        end
    end

    // Busy from accept until the item leaves the last cell.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (in_accept) begin
            busy_reg <= 1'b1;
        end else if (res_valid) begin
            busy_reg <= 1'b0;
        end
    end

    // Output register with one hold slot behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (hold_valid_reg) begin
                out_valid_reg  <= 1'b1;
                hold_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= res_valid;
            end
        end else if (res_valid) begin
            hold_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            if (hold_valid_reg) begin
                out_data_reg <= hold_data_reg;
            end else if (res_valid) begin
                out_data_reg <= res_data;
            end
        end else if (res_valid) begin
            hold_data_reg <= res_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'(out_data_reg);

endmodule

[src/tplp_cell.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tplp_cell
// One lowpass stage with its own DC blocker, with a products register and a sum register.
// ---------------------------------------------------------------------------
module tplp_cell
    import tplp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  tplp_coef_t coef,
    input  tplp_link_t link_in,
    output tplp_link_t link_out
);

    logic signed [STATE_W-1:0] dc_reg, dc_next;
    logic signed [STATE_W-1:0] prev_reg, prev_next;

    logic                      mid_valid_reg;
    logic signed [49:0]        p_feed_reg, p_fb_reg, p_keep_reg, p_take_reg;

    logic                      out_valid_reg;
    logic signed [STATE_W-1:0] out_x_reg;

    logic signed [16:0]        feed_s;
    logic signed [17:0]        fb_s;
    logic signed [STATE_W:0]   ac;
    logic signed [49:0]        prod_feed, prod_fb, prod_keep, prod_take;
    logic signed [51:0]        acc_sum, dc_sum;

    // Products register: the four products of this item.
    assign feed_s    = signed'({1'b0, coef.feed});
    assign fb_s      = signed'({1'b0, coef.fb});
    assign ac        = (STATE_W+1)'(link_in.x) - (STATE_W+1)'(dc_reg);
    assign prod_feed = feed_s * ac;
    assign prod_fb   = fb_s * prev_reg;
    assign prod_keep = dc_reg * 18'(DC_KEEP);
    assign prod_take = link_in.x * 18'(DC_TAKE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
        end else begin
            mid_valid_reg <= link_in.valid;
        end
        if (link_in.valid) begin
            p_feed_reg <= prod_feed;
            p_fb_reg   <= prod_fb;
            p_keep_reg <= prod_keep;
            p_take_reg <= prod_take;
        end
    end

    // Sum register: sums, rounding and the state update.
    assign acc_sum   = 52'(p_feed_reg) + 52'(p_fb_reg);
    assign dc_sum    = 52'(p_keep_reg) + 52'(p_take_reg);
    assign prev_next = round_sat16(acc_sum);
    assign dc_next   = round_sat16(dc_sum);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dc_reg        <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= mid_valid_reg;
            if (mid_valid_reg) begin
                dc_reg   <= dc_next;
                prev_reg <= prev_next;
            end
        end
        if (mid_valid_reg) begin
            out_x_reg <= prev_next;
        end
    end

    assign link_out.valid = out_valid_reg;
    assign link_out.x     = out_x_reg;

endmodule

[src/tplp_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tplp_checker
// Port-level checks of the lowpass block, bound to the top level.
// ---------------------------------------------------------------------------
`include "three_pole_lowpass_with_dc_block_top_assert.svh"

module tplp_checker #(
    parameter int TDATA_W = 24
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic               cfg_valid,
    input logic               cfg_ready
);

    // A stalled result keeps its value.
    `TPLP_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // Reset leaves no result pending.
    `TPLP_ASSERT_ALWAYS(a_rst_empty, !aresetn |=> !m_tvalid, "result valid after reset")

    // Only one item is in the cells at a time.
    `TPLP_ASSERT(a_one_item, s_tvalid && s_tready |=> !s_tready, "second item taken at once")

    // No result can appear the cycle right after an item is taken.
    `TPLP_ASSERT(a_min_latency, $rose(m_tvalid) |-> !$past(s_tvalid && s_tready), "result too early")

    // Configuration writes are never refused.
    `TPLP_ASSERT(a_cfg_ready, cfg_valid |-> cfg_ready, "configuration write stalled")

endmodule

bind three_pole_lowpass_with_dc_block_top tplp_checker #(.TDATA_W(TDATA_W)) u_tplp_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

[tb/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the three-pole lowpass with DC blocking.
// A queue-fed driver streams signed samples into the block while a monitor
// checks every filtered sample against a bit-exact fixed-point filter model
// kept in the bench. Gains are rewritten between phases while the block is
// idle, and both stream sides idle and stall at random.
// ---------------------------------------------------------------------------
module tb;
    import tplp_pkg::*;

    localparam int STAGES      = 3;
    localparam int SAMPLE_BITS = 24;
    localparam int DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int FRAC        = 32 - SAMPLE_BITS;

    // Filter constants: 0.995 decay in Q0.16 and its complement.
    localparam longint DECAY_KEEP = 65208;
    localparam longint DECAY_TAKE = 65536 - DECAY_KEEP;
    localparam logic [15:0] FEED_DEFAULT = 16'd4365;
    localparam logic [15:0] POLE_DEFAULT = 16'd56806;

    // Lowest register index that the block does not decode.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = CFG_IDX_W'(2);

    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 50;
    localparam int HOLD_CYCLES   = 80;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 4 * STAGES + 10;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [DATA_W-1:0]    m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COEF_W-1:0]    cfg_data  = '0;

    // Filter model state and its copy of the gains.
    logic signed [31:0] dc_level [STAGES];
    logic signed [31:0] pole_out [STAGES];
    logic [15:0]        feed_gain_m;
    logic [15:0]        pole_gain_m;

    // Samples waiting to be sent and filtered samples waiting to arrive.
    logic [SAMPLE_BITS-1:0] sample_backlog[$];
    logic [SAMPLE_BITS-1:0] expected_samples[$];

    int n_offered     = 0;
    int n_accepted    = 0;
    int n_results     = 0;
    int n_clipped     = 0;
    int n_gain_writes = 0;
    int n_settings    = 0;
    int err_cnt       = 0;
    int cycle_cnt     = 0;
    int s_idle_pct    = 20;
    int m_idle_pct    = 20;
    int hold_token    = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    three_pole_lowpass_with_dc_block_top #(
        .STAGES      (STAGES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Clamp to the signed 32-bit range.
    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Divide by 2^s, rounding half up.
    function automatic logic signed [63:0] round_div(input logic signed [63:0] v, input int s);
        logic signed [63:0] half;
        half = 64'sd1 <<< (s - 1);
        return (v + half) >>> s;
    endfunction

    // Run one sample through every stage and update the model state.
    function automatic logic [SAMPLE_BITS-1:0] filter_sample(input logic [SAMPLE_BITS-1:0] raw);
        logic signed [SAMPLE_BITS-1:0] smp;
        logic signed [63:0] x;
        logic signed [63:0] dc;
        logic signed [63:0] prev;
        logic signed [63:0] b0;
        logic signed [63:0] fb;
        logic signed [63:0] acc;
        logic signed [63:0] res;
        smp = raw;
        x   = smp;
        x   = x <<< FRAC;
        b0  = {48'd0, feed_gain_m};
        fb  = b0 + {48'd0, pole_gain_m};
        for (int k = 0; k < STAGES; k++) begin
            dc   = dc_level[k];
            prev = pole_out[k];
            dc_level[k] = clamp32(round_div(dc * DECAY_KEEP + x * DECAY_TAKE, 16));
            acc = b0 * (x - dc) + fb * prev;
            pole_out[k] = clamp32(round_div(acc, 16));
            x = pole_out[k];
        end
        res = round_div(x, FRAC);
        if (res > SAMPLE_MAX) res = SAMPLE_MAX;
        if (res < SAMPLE_MIN) res = SAMPLE_MIN;
        return res[SAMPLE_BITS-1:0];
    endfunction

    // Mostly full-range noise, with extremes and small values mixed in.
    function automatic logic [SAMPLE_BITS-1:0] random_sample();
        logic signed [SAMPLE_BITS-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = SAMPLE_MAX;
            1:       v = SAMPLE_MIN;
            2, 3:    v = SAMPLE_BITS'($signed($urandom_range(0, 4000)) - 2000);
            default: v = SAMPLE_BITS'($urandom);
        endcase
        return v;
    endfunction

    // Write one gain register and mirror it in the model.
    task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_FEED_GAIN: feed_gain_m = val;
            REG_POLE_GAIN: pole_gain_m = val;
            default: ;
        endcase
        n_gain_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Set both gains, sometimes after a write to an undecoded index.
    task automatic set_gains(input logic [15:0] feed, input logic [15:0] pole);
        if ($urandom_range(0, 2) == 0)
            write_gain(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, 2**CFG_IDX_W - 1)),
                       COEF_W'($urandom));
        write_gain(REG_FEED_GAIN, feed);
        write_gain(REG_POLE_GAIN, pole);
        n_settings++;
    endtask

    // Wait until every queued sample is sent and every result has come back.
    task automatic wait_drained();
        while (sample_backlog.size() != 0 || n_accepted != n_offered ||
               expected_samples.size() != 0)
            @(posedge aclk);
    endtask

    // Sender: hold an offered item until taken, otherwise maybe offer the next.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && n_accepted != n_offered) begin
            // Item still waiting for the block.
        end else if (sample_backlog.size() != 0 && $urandom_range(0, 99) >= s_idle_pct) begin
            s_tdata  <= DATA_W'(sample_backlog.pop_front());
            s_tvalid <= 1'b1;
            n_offered++;
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Accepted input items feed the filter model.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            expected_samples.push_back(filter_sample(s_tdata[SAMPLE_BITS-1:0]));
            n_accepted++;
        end
    end

    // Receiver: random stalls, plus a long hold-off when asked for one.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= m_idle_pct);
        end
    end

    // Compare each result with the oldest expected sample.
    always @(posedge aclk) begin : out_check
        logic [SAMPLE_BITS-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_samples.size() == 0) begin
                $error("sample_out: unexpected result %0d", $signed(m_tdata[SAMPLE_BITS-1:0]));
                err_cnt++;
            end else begin
                want = expected_samples.pop_front();
                n_results++;
                if ($signed(want) == SAMPLE_MAX || $signed(want) == SAMPLE_MIN)
                    n_clipped++;
                if (m_tdata[SAMPLE_BITS-1:0] !== want) begin
                    $error("sample_out: expected %0d, got %0d",
                           $signed(want), $signed(m_tdata[SAMPLE_BITS-1:0]));
                    err_cnt++;
                end
            end
        end
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Stimulus sequence.
    initial begin
        logic [15:0] feed;
        logic [15:0] pole;

        feed_gain_m = FEED_DEFAULT;
        pole_gain_m = POLE_DEFAULT;
        for (int k = 0; k < STAGES; k++) begin
            dc_level[k] = '0;
            pole_out[k] = '0;
        end
        aresetn = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset gains: full-scale steps, sign flips and alternating bit patterns.
        n_settings++;
        sample_backlog.push_back(24'sd0);
        repeat (3) sample_backlog.push_back(SAMPLE_MAX);
        repeat (2) sample_backlog.push_back(SAMPLE_MIN);
        sample_backlog.push_back(24'sd1);
        sample_backlog.push_back(-24'sd1);
        sample_backlog.push_back(24'h555555);
        sample_backlog.push_back(24'hAAAAAA);
        sample_backlog.push_back(24'sd0);
        sample_backlog.push_back(24'sd4194304);
        wait_drained();

        // Unstable gains: the state and the output run into saturation.
        write_gain(REG_SPARE_FIRST, 16'hFFFF);
        write_gain(CFG_IDX_W'(2**CFG_IDX_W - 1), 16'h0000);
        set_gains(16'hFFFF, 16'hFFFF);
        repeat (3) sample_backlog.push_back(SAMPLE_MAX);
        repeat (3) sample_backlog.push_back(SAMPLE_MIN);
        sample_backlog.push_back(24'sd0);
        sample_backlog.push_back(24'sd1);
        wait_drained();

        // Zero gains: the output collapses to zero.
        set_gains(16'h0000, 16'h0000);
        sample_backlog.push_back(SAMPLE_MAX);
        sample_backlog.push_back(SAMPLE_MIN);
        sample_backlog.push_back(24'sd12345);
        sample_backlog.push_back(24'sd0);
        wait_drained();

        // Random phases, one gain setting each.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            s_idle_pct = 20;
            m_idle_pct = 20;
            case (ph)
                0, 1: begin
                    feed = 16'($urandom_range(1000, 8000));
                    pole = 16'($urandom_range(50000, 65535 - feed));
                end
                2: begin
                    feed = 16'hFFFF;
                    pole = 16'h0000;
                end
                4: begin
                    feed = 16'(FEED_DEFAULT + $urandom_range(0, 500));
                    pole = 16'(POLE_DEFAULT + $urandom_range(0, 3000));
                end
                5: begin
                    feed = 16'h0000;
                    pole = 16'hFFFF;
                end
                6: begin
                    feed = 16'($urandom_range(1, 200));
                    pole = 16'(16'hFFFF - feed - $urandom_range(0, 50));
                end
                default: begin
                    feed = 16'($urandom);
                    pole = 16'($urandom);
                end
            endcase
            set_gains(feed, pole);
            // Long hold-off on the result side while the sender keeps offering.
            if (ph == 1) begin
                s_idle_pct = 0;
                m_idle_pct = 0;
                hold_token++;
            end
            // A stretch with no idling on either side.
            if (ph == 4) begin
                s_idle_pct = 0;
                m_idle_pct = 0;
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
                sample_backlog.push_back(random_sample());
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("tb: %0d samples filtered, %0d results checked, %0d at the output limits",
                 n_accepted, n_results, n_clipped);
        $display("tb: %0d gain writes over %0d settings, zero and unstable gains included",
                 n_gain_writes, n_settings);
        if (err_cnt == 0 && expected_samples.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
